@@ hw/rtl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/mqui_pkg.sv @@
// -----------------------------------------------------------------------------
// mqui_pkg
// Types, constants and helpers of the message queue with urgent insert.
// -----------------------------------------------------------------------------
package mqui_pkg;

   localparam int DepthDefault     = 16;
   localparam int SlotBytesDefault = 8;

   localparam int PayloadWidth  = 64;
   localparam int LengthWidth   = 8;
   localparam int CountWidth    = 5;
   localparam int SizeWidth     = 4;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 5;
   localparam int MaskBytes     = PayloadWidth / 8;

   localparam logic [SizeWidth-1:0]  MsgSizeReset  = SizeWidth'(8);
   localparam logic [CountWidth-1:0] CapacityReset = CountWidth'(16);

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_URGENT  = 2'd1,
      CMD_RECEIVE = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MESSAGE_SIZE = 2'd0,
      CSR_CAPACITY     = 2'd1
   } csr_index_type;

   typedef struct packed {
      command_type             command;
      logic [LengthWidth-1:0]  length;
      logic [PayloadWidth-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [PayloadWidth-1:0] read_data;
      logic [SizeWidth-1:0]    copied_bytes;
      logic [CountWidth-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic execute;
      logic load_rsp;
   } ctrl_cmd_type;

   function automatic logic [PayloadWidth-1:0] byte_mask(input logic [SizeWidth-1:0] n);
      logic [PayloadWidth-1:0] mask;
      mask = '0;
      for (int b = 0; b < MaskBytes; b++) begin
         mask[b*8 +: 8] = {8{SizeWidth'(b) < n}};
      end
      return mask;
   endfunction

endpackage

@@ hw/rtl/message_queue_with_urgent_insert_top.sv @@
// -----------------------------------------------------------------------------
// message_queue_with_urgent_insert_top
// Bounded message queue of fixed-size slots with tail send, head urgent insert
// and head receive.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: send (append at tail), urgent
//   (insert at head) or receive (remove from head). rsp_* returns exactly one
//   result per command: status, read data, copied bytes and occupancy.
//   csr_* writes message_size (index 0) or capacity (index 1); csr_ready is
//   always high. Write configuration only while no command is in flight.
// Sequence:
//   A command accepted into the item register is executed in state EXEC and
//   its result is loaded into the response register in state FINISH once
//   that register is free, which raises rsp_valid. req_ready returns high
//   only after that load, so a new command is accepted only once the last
//   one has passed the accept / execute / load sequence around the slots.
// Reset:
//   Synchronous reset empties the queue, sets head to slot zero, message_size
//   to 8 and capacity to 16. Slot contents are not cleared.
// Stall:
//   A waiting response holds in its register; one further command is accepted
//   and executed meanwhile, then holds until the response transfer completes.
// -----------------------------------------------------------------------------
module message_queue_with_urgent_insert_top #(
   parameter int DEPTH      = mqui_pkg::DepthDefault,
   parameter int SLOT_BYTES = mqui_pkg::SlotBytesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mqui_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mqui_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mqui_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mqui_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import mqui_pkg::*;

   ctrl_cmd_type cmd;

   assign csr_ready = 1'b1;

   mqui_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mqui_dp #(
      .DEPTH      (DEPTH),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ hw/rtl/mqui_ctrl.sv @@
// -----------------------------------------------------------------------------
// mqui_ctrl
// Sequencer: accept a command, execute it, then load the response register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqui_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mqui_pkg::ctrl_cmd_type cmd
);
   import mqui_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      EXEC,
      FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;

   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign cmd.load_item = req_valid && (state_ff == IDLE);
   assign cmd.execute   = (state_ff == EXEC);
   assign cmd.load_rsp  = (state_ff == FINISH) && rsp_free;
   assign rsp_valid_in  = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               state_ff <= FINISH;
            end
            FINISH: begin
               if (rsp_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(a_accept_to_exec, clock, reset, req_valid && req_ready, state_ff == EXEC)
   `ASSERT_NEXT(a_finish_waits, clock, reset, state_ff == FINISH && !rsp_free, state_ff == FINISH && rsp_valid_ff)
   `ASSERT_IMPLY(a_load_only_free, clock, reset, cmd.load_rsp, !rsp_valid_ff || rsp_ready)

endmodule

@@ hw/rtl/mqui_dp.sv @@
// -----------------------------------------------------------------------------
// mqui_dp
// Datapath: configuration, slot ring memory, head and count, response register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqui_dp #(
   parameter int DEPTH      = mqui_pkg::DepthDefault,
   parameter int SLOT_BYTES = mqui_pkg::SlotBytesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mqui_pkg::ctrl_cmd_type               cmd,
   input  mqui_pkg::req_type                    req_data,
   output mqui_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic [mqui_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [mqui_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import mqui_pkg::*;

   localparam int IdxWidth  = $clog2(DEPTH);
   localparam int SlotWidth = SLOT_BYTES * 8;
   localparam int SumWidth  = ((IdxWidth > CountWidth) ? IdxWidth : CountWidth) + 1;
   localparam int CountMax  = (1 << CountWidth) - 1;
   localparam logic [CountWidth-1:0] CapLimit =
      CountWidth'((DEPTH < CountMax) ? DEPTH : CountMax);
   localparam logic [SizeWidth-1:0] SizeLimit = SizeWidth'(SLOT_BYTES);
   localparam logic [IdxWidth-1:0]  LastIdx   = IdxWidth'(DEPTH - 1);
   localparam logic [SumWidth-1:0]  DepthSum  = SumWidth'(DEPTH);

   logic [SizeWidth-1:0]    msg_size_ff;
   logic [CountWidth-1:0]   capacity_ff;
   logic [IdxWidth-1:0]     head_ff;
   logic [IdxWidth-1:0]     head_in;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   req_type                 item_ff;
   status_type              status_ff;
   status_type              status_in;
   logic [SizeWidth-1:0]    copied_ff;
   logic [SizeWidth-1:0]    copied_in;
   logic [SlotWidth-1:0]    rd_ff;
   rsp_type                 rsp_ff;
   logic [SlotWidth-1:0]    slot_mem [DEPTH];

   logic [SizeWidth-1:0]    eff_size;
   logic [CountWidth-1:0]   eff_cap;
   logic [LengthWidth-1:0]  size_ext;
   logic                    too_large;
   logic                    is_full;
   logic [SumWidth-1:0]     tail_sum;
   logic [IdxWidth-1:0]     tail_idx;
   logic [IdxWidth-1:0]     head_dec;
   logic [IdxWidth-1:0]     head_inc;
   logic [SizeWidth-1:0]    copy_len;
   logic [SlotWidth-1:0]    store_data;
   logic                    wr_en;
   logic [IdxWidth-1:0]     wr_idx;

   assign eff_size  = (msg_size_ff > SizeLimit) ? SizeLimit : msg_size_ff;
   assign eff_cap   = (capacity_ff > CapLimit) ? CapLimit : capacity_ff;
   assign size_ext  = {{(LengthWidth - SizeWidth){1'b0}}, eff_size};
   assign too_large = item_ff.length > size_ext;
   assign is_full   = count_ff >= eff_cap;
   assign tail_sum  = SumWidth'(head_ff) + SumWidth'(count_ff);
   assign tail_idx  = (tail_sum >= DepthSum) ? IdxWidth'(tail_sum - DepthSum)
                                              : IdxWidth'(tail_sum);
   assign head_dec  = (head_ff == '0) ? LastIdx : head_ff - 1'b1;
   assign head_inc  = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
   assign copy_len  = (item_ff.length < size_ext) ? item_ff.length[SizeWidth-1:0] : eff_size;
   assign store_data =
      SlotWidth'(item_ff.payload & byte_mask(item_ff.length[SizeWidth-1:0]));
   assign rsp_data  = rsp_ff;

   always_comb begin
      status_in = STATUS_OK;
      copied_in = '0;
      head_in   = head_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_idx    = tail_idx;
      unique case (item_ff.command)
         CMD_SEND, CMD_URGENT: begin
            priority if (too_large) begin
               status_in = STATUS_TOO_LARGE;
            end else if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (item_ff.command == CMD_URGENT) begin
                  head_in = head_dec;
                  wr_idx  = head_dec;
               end
            end
         end
         CMD_RECEIVE: begin
            if (count_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               copied_in = copy_len;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_size_ff <= MsgSizeReset;
         capacity_ff <= CapacityReset;
         head_ff     <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MESSAGE_SIZE: msg_size_ff <= csr_wdata[SizeWidth-1:0];
               CSR_CAPACITY:     capacity_ff <= csr_wdata[CountWidth-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.execute) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         copied_ff <= copied_in;
         rd_ff     <= slot_mem[head_ff];
         if (wr_en) begin
            slot_mem[wr_idx] <= store_data;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.read_data    <= PayloadWidth'(rd_ff) & byte_mask(copied_ff);
         rsp_ff.copied_bytes <= copied_ff;
         rsp_ff.occupancy    <= count_ff;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CapLimit)
   `ASSERT_ALWAYS(a_head_bound, clock, reset, head_ff <= LastIdx)
   `ASSERT_NEXT(a_receive_drains, clock, reset, cmd.execute && item_ff.command == CMD_RECEIVE && count_ff != '0, count_ff == $past(count_ff) - 1'b1)

endmodule
